/* rtl/blr_pkg.sv */
package blr_pkg;

  // Coordinate width and derived datapath widths
  localparam int COORD_BITS = 12;
  localparam int DELTA_W    = COORD_BITS + 1;  // signed endpoint difference
  localparam int INC_S_W    = COORD_BITS + 2;  // straight increment, 2*|minor|
  localparam int ERR_W      = COORD_BITS + 4;  // signed error term and diagonal increment

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [ERR_W-1:0]      err_t;
  typedef logic        [INC_S_W-1:0]    inc_s_t;

  // Input opcodes
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_e;

endpackage

/* rtl/bresenham_line_rasterizer.sv */
// Bresenham line rasterizer.
// Input channel (in_valid_i / in_stall_o): opcode_i = OP_LOAD latches the
// endpoints x_start/y_start and x_end/y_end and sets up the line without a
// result; opcode_i = OP_STEP emits the next raster point of the active line.
// A step with no active line is consumed silently.
// Output channel (out_valid_o / out_stall_i): one transaction per point,
// point_x_o/point_y_o plus last_point_o on the end point, after which the
// line goes inactive. Every point appears once; a zero-length line gives a
// single point flagged last.
// Each point is registered in the output register or, under stall, the skid entry.
// Throughput: one item per cycle while in_stall_o is low; all setup and the error update are one
// pass of logic between the line state registers and the output register.
// The output register is backed by a one-entry skid register, so in_stall_o
// is registered and rises once a point lands in the skid entry while the
// receiver stalls a full output register; it clears the cycle after the
// receiver takes a point.
// Reset clears the active-line flag and both output entries; no line is
// active until the first load.
module bresenham_line_rasterizer
  import blr_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         opcode_i,
  input  logic signed [COORD_BITS-1:0] x_start_i,
  input  logic signed [COORD_BITS-1:0] y_start_i,
  input  logic signed [COORD_BITS-1:0] x_end_i,
  input  logic signed [COORD_BITS-1:0] y_end_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0] point_x_o,
  output logic signed [COORD_BITS-1:0] point_y_o,
  output logic                         last_point_o
);

  // Line state
  logic   active_q, active_d;
  coord_t cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  coord_t tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  err_t   err_q, err_d, inc_d_q, inc_d_d;
  inc_s_t inc_s_q, inc_s_d;
  logic   neg_x_q, neg_x_d, neg_y_q, neg_y_d, maj_x_q, maj_x_d;

  // Output register and skid entry
  logic   out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;
  coord_t out_x_q, out_x_d, out_y_q, out_y_d, skid_x_q, skid_x_d, skid_y_q, skid_y_d;
  logic   out_last_q, out_last_d, skid_last_q, skid_last_d;

  logic   in_acc;
  logic   is_load;

  // Load setup signals
  logic signed [DELTA_W-1:0] dx, dy;
  logic [COORD_BITS-1:0]     adx, ady, amaj, amin;
  logic                      ld_maj_x;

  // Step signals
  logic   at_end;
  coord_t step_x, step_y;
  logic   res_vld, res_last;
  coord_t res_x, res_y;
  err_t   inc_s_ext;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign is_load = (opcode_i == OP_LOAD);

  // Endpoint deltas, magnitudes and major axis
  always_comb begin
    dx       = DELTA_W'(x_end_i) - DELTA_W'(x_start_i);
    dy       = DELTA_W'(y_end_i) - DELTA_W'(y_start_i);
    adx      = dx[DELTA_W-1] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
    ady      = dy[DELTA_W-1] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
    ld_maj_x = adx > ady;
    amaj     = ld_maj_x ? adx : ady;
    amin     = ld_maj_x ? ady : adx;
  end

  // Step: end test, axis moves and error update
  always_comb begin
    at_end    = maj_x_q ? (cur_x_q == tgt_x_q) : (cur_y_q == tgt_y_q);
    step_x    = neg_x_q ? cur_x_q - coord_t'(1) : cur_x_q + coord_t'(1);
    step_y    = neg_y_q ? cur_y_q - coord_t'(1) : cur_y_q + coord_t'(1);
    inc_s_ext = err_t'(inc_s_q);
  end

  // Next line state and result of the accepted item
  always_comb begin
    active_d = active_q;
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    tgt_x_d  = tgt_x_q;
    tgt_y_d  = tgt_y_q;
    err_d    = err_q;
    inc_s_d  = inc_s_q;
    inc_d_d  = inc_d_q;
    neg_x_d  = neg_x_q;
    neg_y_d  = neg_y_q;
    maj_x_d  = maj_x_q;
    res_vld  = 1'b0;
    res_last = at_end;
    res_x    = at_end ? tgt_x_q : cur_x_q;
    res_y    = at_end ? tgt_y_q : cur_y_q;
    if (in_acc) begin
      if (is_load) begin
        active_d = 1'b1;
        cur_x_d  = x_start_i;
        cur_y_d  = y_start_i;
        tgt_x_d  = x_end_i;
        tgt_y_d  = y_end_i;
        neg_x_d  = (dx <= 0);
        neg_y_d  = (dy <= 0);
        maj_x_d  = ld_maj_x;
        inc_s_d  = {1'b0, amin, 1'b0};
        err_d    = err_t'({amin, 1'b0}) - err_t'(amaj);
        inc_d_d  = err_t'({amin, 1'b0}) - err_t'({amaj, 1'b0});
      end else if (active_q) begin
        res_vld = 1'b1;
        if (at_end) begin
          active_d = 1'b0;
        end else begin
          // Diagonal move when the error is positive
          if (err_q > 0) begin
            err_d = err_q + inc_d_q;
            if (maj_x_q) begin
              cur_y_d = step_y;
            end else begin
              cur_x_d = step_x;
            end
          end else begin
            err_d = err_q + inc_s_ext;
          end
          if (maj_x_q) begin
            cur_x_d = step_x;
          end else begin
            cur_y_d = step_y;
          end
        end
      end
    end
  end

  // Output register with skid entry
  always_comb begin
    out_vld_d   = out_vld_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_last_d  = out_last_q;
    skid_vld_d  = skid_vld_q;
    skid_x_d    = skid_x_q;
    skid_y_d    = skid_y_q;
    skid_last_d = skid_last_q;
    if (!out_vld_q || !out_stall_i) begin
      if (skid_vld_q) begin
        out_vld_d   = 1'b1;
        out_x_d     = skid_x_q;
        out_y_d     = skid_y_q;
        out_last_d  = skid_last_q;
        skid_vld_d  = res_vld;
        skid_x_d    = res_x;
        skid_y_d    = res_y;
        skid_last_d = res_last;
      end else begin
        out_vld_d  = res_vld;
        out_x_d    = res_x;
        out_y_d    = res_y;
        out_last_d = res_last;
      end
    end else if (res_vld) begin
      skid_vld_d  = 1'b1;
      skid_x_d    = res_x;
      skid_y_d    = res_y;
      skid_last_d = res_last;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      active_q   <= active_d;
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    cur_x_q     <= cur_x_d;
    cur_y_q     <= cur_y_d;
    tgt_x_q     <= tgt_x_d;
    tgt_y_q     <= tgt_y_d;
    err_q       <= err_d;
    inc_s_q     <= inc_s_d;
    inc_d_q     <= inc_d_d;
    neg_x_q     <= neg_x_d;
    neg_y_q     <= neg_y_d;
    maj_x_q     <= maj_x_d;
    out_x_q     <= out_x_d;
    out_y_q     <= out_y_d;
    out_last_q  <= out_last_d;
    skid_x_q    <= skid_x_d;
    skid_y_q    <= skid_y_d;
    skid_last_q <= skid_last_d;
  end

  assign in_stall_o   = skid_vld_q;
  assign out_valid_o  = out_vld_q;
  assign point_x_o    = out_x_q;
  assign point_y_o    = out_y_q;
  assign last_point_o = out_last_q;

endmodule

/* rtl/blr_checker.sv */
module blr_checker
  import blr_pkg::*;
(
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         opcode_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic signed [COORD_BITS-1:0] point_x_o,
  input logic signed [COORD_BITS-1:0] point_y_o,
  input logic                         last_point_o
);

  // A stalled output transaction holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(point_x_o) && $stable(point_y_o) && $stable(last_point_o)))
    else $error("output payload changed while stalled");

  // Input stall only while a point is waiting on the output
  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // Input stall only rises after the receiver stalled a point
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall rose without output backpressure");

  // A load into an empty block makes no point
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && in_valid_i && !in_stall_o && (opcode_i == OP_LOAD)) |=> !out_valid_o)
    else $error("load produced a point");

endmodule

bind bresenham_line_rasterizer blr_checker u_blr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .opcode_i     (opcode_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .point_x_o    (point_x_o),
  .point_y_o    (point_y_o),
  .last_point_o (last_point_o)
);
